// ===== hw/rtl/kalman_filter_two_state_macros.svh =====
// Assertion macros for the two-state Kalman filter checker.
// Included by the checker file only; no other dependencies.
`ifndef KALMAN_FILTER_TWO_STATE_MACROS_SVH
`define KALMAN_FILTER_TWO_STATE_MACROS_SVH

// next-cycle implication, masked while reset is high
`define KFTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kfts checker: property failed");

// next-cycle implication that also holds across reset
`define KFTS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("kfts checker: property failed");

`endif

// ===== hw/rtl/kfts_pkg.sv =====
// Types, operand codes and the sequencer microprogram for the Kalman filter.
// Used by kalman_filter_two_state; depends on nothing.
package kfts_pkg;

   typedef enum logic [1:0] {OP_MUL, OP_ADD, OP_SUB, OP_DIV} op_code_type;
   typedef logic [5:0] opnd_type;
   typedef logic [6:0] pc_type;

   typedef struct packed {
      op_code_type op;
      opnd_type    dst;
      opnd_type    srca;
      opnd_type    srcb;
   } uop_type;

   // register indexes on the configuration port
   localparam logic [2:0] REG_TRANS0 = 3'd0;
   localparam logic [2:0] REG_TRANS1 = 3'd1;
   localparam logic [2:0] REG_NOISE0 = 3'd2;
   localparam logic [2:0] REG_NOISE1 = 3'd3;
   localparam logic [2:0] REG_MEAS   = 3'd4;
   localparam logic [2:0] REG_MNOISE = 3'd5;

   // scratch slots (codes below 32 live in the scratch memory)
   localparam opnd_type SC_XM0 = 6'd0;
   localparam opnd_type SC_XM1 = 6'd1;
   localparam opnd_type SC_A0  = 6'd2;
   localparam opnd_type SC_A1  = 6'd3;
   localparam opnd_type SC_A2  = 6'd4;
   localparam opnd_type SC_A3  = 6'd5;
   localparam opnd_type SC_PM0 = 6'd6;
   localparam opnd_type SC_PM1 = 6'd7;
   localparam opnd_type SC_PM2 = 6'd8;
   localparam opnd_type SC_PM3 = 6'd9;
   localparam opnd_type SC_N0  = 6'd10;
   localparam opnd_type SC_N1  = 6'd11;
   localparam opnd_type SC_S   = 6'd12;
   localparam opnd_type SC_K0  = 6'd13;
   localparam opnd_type SC_K1  = 6'd14;
   localparam opnd_type SC_E   = 6'd15;
   localparam opnd_type SC_C0  = 6'd16;
   localparam opnd_type SC_C1  = 6'd17;
   localparam opnd_type SC_TA  = 6'd18;
   localparam opnd_type SC_TB  = 6'd19;
   localparam opnd_type SC_TC  = 6'd20;
   localparam opnd_type SC_TD  = 6'd21;
   localparam opnd_type SC_TE  = 6'd22;

   // register-side operands
   localparam opnd_type OPN_T0   = 6'd32;
   localparam opnd_type OPN_T1   = 6'd33;
   localparam opnd_type OPN_T2   = 6'd34;
   localparam opnd_type OPN_T3   = 6'd35;
   localparam opnd_type OPN_Q0   = 6'd36;
   localparam opnd_type OPN_Q1   = 6'd37;
   localparam opnd_type OPN_Q2   = 6'd38;
   localparam opnd_type OPN_Q3   = 6'd39;
   localparam opnd_type OPN_H0   = 6'd40;
   localparam opnd_type OPN_H1   = 6'd41;
   localparam opnd_type OPN_R    = 6'd42;
   localparam opnd_type OPN_Z    = 6'd43;
   localparam opnd_type OPN_X0   = 6'd44;
   localparam opnd_type OPN_X1   = 6'd45;
   localparam opnd_type OPN_P0   = 6'd46;
   localparam opnd_type OPN_P1   = 6'd47;
   localparam opnd_type OPN_P2   = 6'd48;
   localparam opnd_type OPN_P3   = 6'd49;
   localparam opnd_type OPN_ONE  = 6'd50;
   localparam opnd_type OPN_ZERO = 6'd51;

   localparam int     UCODE_LEN = 78;
   localparam pc_type LAST_PC   = pc_type'(UCODE_LEN - 1);

   function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
      logic signed [31:0] r;
      if (v > 65'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -65'sh0_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic uop_type mk(input op_code_type op, input opnd_type d,
                                  input opnd_type a, input opnd_type b);
      uop_type u;
      u.op   = op;
      u.dst  = d;
      u.srca = a;
      u.srcb = b;
      return u;
   endfunction

   // predict, gain, covariance update, state update
   function automatic uop_type ucode(input pc_type pc);
      uop_type u;
      case (pc)
         7'd0:  u = mk(OP_MUL, SC_TA,  OPN_T0, OPN_X0);
         7'd1:  u = mk(OP_MUL, SC_TB,  OPN_T1, OPN_X1);
         7'd2:  u = mk(OP_ADD, SC_XM0, SC_TA,  SC_TB);
         7'd3:  u = mk(OP_MUL, SC_TA,  OPN_T2, OPN_X0);
         7'd4:  u = mk(OP_MUL, SC_TB,  OPN_T3, OPN_X1);
         7'd5:  u = mk(OP_ADD, SC_XM1, SC_TA,  SC_TB);
         7'd6:  u = mk(OP_MUL, SC_TA,  OPN_T0, OPN_P0);
         7'd7:  u = mk(OP_MUL, SC_TB,  OPN_T1, OPN_P2);
         7'd8:  u = mk(OP_ADD, SC_A0,  SC_TA,  SC_TB);
         7'd9:  u = mk(OP_MUL, SC_TA,  OPN_T0, OPN_P1);
         7'd10: u = mk(OP_MUL, SC_TB,  OPN_T1, OPN_P3);
         7'd11: u = mk(OP_ADD, SC_A1,  SC_TA,  SC_TB);
         7'd12: u = mk(OP_MUL, SC_TA,  OPN_T2, OPN_P0);
         7'd13: u = mk(OP_MUL, SC_TB,  OPN_T3, OPN_P2);
         7'd14: u = mk(OP_ADD, SC_A2,  SC_TA,  SC_TB);
         7'd15: u = mk(OP_MUL, SC_TA,  OPN_T2, OPN_P1);
         7'd16: u = mk(OP_MUL, SC_TB,  OPN_T3, OPN_P3);
         7'd17: u = mk(OP_ADD, SC_A3,  SC_TA,  SC_TB);
         7'd18: u = mk(OP_MUL, SC_TA,  SC_A0,  OPN_T0);
         7'd19: u = mk(OP_MUL, SC_TB,  SC_A1,  OPN_T1);
         7'd20: u = mk(OP_ADD, SC_TA,  SC_TA,  SC_TB);
         7'd21: u = mk(OP_ADD, SC_PM0, SC_TA,  OPN_Q0);
         7'd22: u = mk(OP_MUL, SC_TA,  SC_A0,  OPN_T2);
         7'd23: u = mk(OP_MUL, SC_TB,  SC_A1,  OPN_T3);
         7'd24: u = mk(OP_ADD, SC_TA,  SC_TA,  SC_TB);
         7'd25: u = mk(OP_ADD, SC_PM1, SC_TA,  OPN_Q1);
         7'd26: u = mk(OP_MUL, SC_TA,  SC_A2,  OPN_T0);
         7'd27: u = mk(OP_MUL, SC_TB,  SC_A3,  OPN_T1);
         7'd28: u = mk(OP_ADD, SC_TA,  SC_TA,  SC_TB);
         7'd29: u = mk(OP_ADD, SC_PM2, SC_TA,  OPN_Q2);
         7'd30: u = mk(OP_MUL, SC_TA,  SC_A2,  OPN_T2);
         7'd31: u = mk(OP_MUL, SC_TB,  SC_A3,  OPN_T3);
         7'd32: u = mk(OP_ADD, SC_TA,  SC_TA,  SC_TB);
         7'd33: u = mk(OP_ADD, SC_PM3, SC_TA,  OPN_Q3);
         7'd34: u = mk(OP_MUL, SC_TA,  OPN_H0, SC_PM0);
         7'd35: u = mk(OP_MUL, SC_TB,  OPN_H1, SC_PM2);
         7'd36: u = mk(OP_ADD, SC_TC,  SC_TA,  SC_TB);
         7'd37: u = mk(OP_MUL, SC_TC,  SC_TC,  OPN_H0);
         7'd38: u = mk(OP_MUL, SC_TA,  OPN_H0, SC_PM1);
         7'd39: u = mk(OP_MUL, SC_TB,  OPN_H1, SC_PM3);
         7'd40: u = mk(OP_ADD, SC_TD,  SC_TA,  SC_TB);
         7'd41: u = mk(OP_MUL, SC_TD,  SC_TD,  OPN_H1);
         7'd42: u = mk(OP_ADD, SC_TC,  SC_TC,  SC_TD);
         7'd43: u = mk(OP_ADD, SC_S,   SC_TC,  OPN_R);
         7'd44: u = mk(OP_MUL, SC_TA,  OPN_H0, SC_PM0);
         7'd45: u = mk(OP_MUL, SC_TB,  OPN_H1, SC_PM1);
         7'd46: u = mk(OP_ADD, SC_N0,  SC_TA,  SC_TB);
         7'd47: u = mk(OP_MUL, SC_TA,  OPN_H0, SC_PM2);
         7'd48: u = mk(OP_MUL, SC_TB,  OPN_H1, SC_PM3);
         7'd49: u = mk(OP_ADD, SC_N1,  SC_TA,  SC_TB);
         7'd50: u = mk(OP_DIV, SC_K0,  SC_N0,  SC_S);
         7'd51: u = mk(OP_DIV, SC_K1,  SC_N1,  SC_S);
         7'd52: u = mk(OP_MUL, SC_C0,  SC_K0,  OPN_H0);
         7'd53: u = mk(OP_MUL, SC_C1,  SC_K0,  OPN_H1);
         7'd54: u = mk(OP_SUB, SC_TE,  OPN_ONE, SC_C0);
         7'd55: u = mk(OP_MUL, SC_TA,  SC_TE,  SC_PM0);
         7'd56: u = mk(OP_MUL, SC_TB,  SC_C1,  SC_PM2);
         7'd57: u = mk(OP_SUB, OPN_P0, SC_TA,  SC_TB);
         7'd58: u = mk(OP_MUL, SC_TA,  SC_TE,  SC_PM1);
         7'd59: u = mk(OP_MUL, SC_TB,  SC_C1,  SC_PM3);
         7'd60: u = mk(OP_SUB, OPN_P1, SC_TA,  SC_TB);
         7'd61: u = mk(OP_MUL, SC_C0,  SC_K1,  OPN_H0);
         7'd62: u = mk(OP_MUL, SC_C1,  SC_K1,  OPN_H1);
         7'd63: u = mk(OP_SUB, SC_TE,  OPN_ONE, SC_C1);
         7'd64: u = mk(OP_MUL, SC_TA,  SC_TE,  SC_PM2);
         7'd65: u = mk(OP_MUL, SC_TB,  SC_C0,  SC_PM0);
         7'd66: u = mk(OP_SUB, OPN_P2, SC_TA,  SC_TB);
         7'd67: u = mk(OP_MUL, SC_TA,  SC_TE,  SC_PM3);
         7'd68: u = mk(OP_MUL, SC_TB,  SC_C0,  SC_PM1);
         7'd69: u = mk(OP_SUB, OPN_P3, SC_TA,  SC_TB);
         7'd70: u = mk(OP_MUL, SC_TA,  OPN_H0, SC_XM0);
         7'd71: u = mk(OP_MUL, SC_TB,  OPN_H1, SC_XM1);
         7'd72: u = mk(OP_ADD, SC_TA,  SC_TA,  SC_TB);
         7'd73: u = mk(OP_SUB, SC_E,   OPN_Z,  SC_TA);
         7'd74: u = mk(OP_MUL, SC_TA,  SC_K0,  SC_E);
         7'd75: u = mk(OP_ADD, OPN_X0, SC_XM0, SC_TA);
         7'd76: u = mk(OP_MUL, SC_TA,  SC_K1,  SC_E);
         7'd77: u = mk(OP_ADD, OPN_X1, SC_XM1, SC_TA);
         default: u = mk(OP_ADD, SC_TA, OPN_ZERO, OPN_ZERO);
      endcase
      return u;
   endfunction

endpackage

// ===== hw/rtl/kalman_filter_two_state.sv =====
// Two-state Kalman filter with scalar measurement, one shared multiply/add/divide unit.
// Uses kfts_pkg for the microprogram, operand codes and saturation.
// Runs the microprogram one micro-op at a time: 46 multiplies (fetch, execute, MULFIN),
// 30 adds/subtracts (fetch, execute), 2 bit-serial divides (fetch, execute, DIVRUN, DIVFIN;
// fetch, execute on a zero innovation variance). A new beat is accepted only when idle; a
// finished result waits for the previous one to drain. Sync reset restores all defaults.
module kalman_filter_two_state #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] measurement
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] first_estimate, [63:32] second_estimate
   output logic        rsp_tuser,   // [0] divide_fault
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   localparam int NW = 32 + FRAC_BITS;
   localparam int CW = $clog2(NW);
   localparam logic signed [31:0] ONE_VAL = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] RND_VAL = 64'sd1 <<< (FRAC_BITS - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_FETCH, ST_EXEC, ST_MULFIN, ST_DIVRUN, ST_DIVFIN, ST_FINISH
   } state_type;

   state_type          state_ff;
   kfts_pkg::pc_type   pc_ff;
   kfts_pkg::uop_type  uop;

   logic [63:0] trans0_ff, trans1_ff, noise0_ff, noise1_ff, meas_ff;
   logic [30:0] mnoise_ff;

   logic signed [31:0] x_ff [2];
   logic signed [31:0] p_ff [4];
   logic signed [31:0] z_ff;
   logic               fault_ff;

   logic signed [31:0] scratch_mem [32];
   logic signed [31:0] rda_ff, rdb_ff;
   logic signed [31:0] opa, opb;

   logic signed [63:0] prod_ff;
   logic [NW-1:0]      quo_ff;
   logic [31:0]        rem_ff, den_ff;
   logic [CW-1:0]      cnt_ff;
   logic               div_neg_ff;

   logic               rsp_tvalid_ff;
   logic [63:0]        rsp_tdata_ff;
   logic               rsp_tuser_ff;

   logic               wb_in;
   logic signed [31:0] wb_data_in;
   logic [32:0]        trial;
   logic signed [63:0] rnd;
   logic signed [63:0] shifted;
   logic               csr_wr;

   assign uop        = kfts_pkg::ucode(pc_ff);
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      unique case (csr_paddr[5:3])
         kfts_pkg::REG_TRANS0: csr_prdata = trans0_ff;
         kfts_pkg::REG_TRANS1: csr_prdata = trans1_ff;
         kfts_pkg::REG_NOISE0: csr_prdata = noise0_ff;
         kfts_pkg::REG_NOISE1: csr_prdata = noise1_ff;
         kfts_pkg::REG_MEAS:   csr_prdata = meas_ff;
         kfts_pkg::REG_MNOISE: csr_prdata = {33'd0, mnoise_ff};
         default:              csr_prdata = 64'd0;
      endcase
   end

   function automatic logic signed [31:0] opnd_val(input kfts_pkg::opnd_type c,
                                                   input logic signed [31:0] memval);
      logic signed [31:0] v;
      if (c < 6'd32) begin
         v = memval;
      end else begin
         unique case (c)
            kfts_pkg::OPN_T0:  v = trans0_ff[63:32];
            kfts_pkg::OPN_T1:  v = trans0_ff[31:0];
            kfts_pkg::OPN_T2:  v = trans1_ff[63:32];
            kfts_pkg::OPN_T3:  v = trans1_ff[31:0];
            kfts_pkg::OPN_Q0:  v = noise0_ff[63:32];
            kfts_pkg::OPN_Q1:  v = noise0_ff[31:0];
            kfts_pkg::OPN_Q2:  v = noise1_ff[63:32];
            kfts_pkg::OPN_Q3:  v = noise1_ff[31:0];
            kfts_pkg::OPN_H0:  v = meas_ff[63:32];
            kfts_pkg::OPN_H1:  v = meas_ff[31:0];
            kfts_pkg::OPN_R:   v = {1'b0, mnoise_ff};
            kfts_pkg::OPN_Z:   v = z_ff;
            kfts_pkg::OPN_X0:  v = x_ff[0];
            kfts_pkg::OPN_X1:  v = x_ff[1];
            kfts_pkg::OPN_P0:  v = p_ff[0];
            kfts_pkg::OPN_P1:  v = p_ff[1];
            kfts_pkg::OPN_P2:  v = p_ff[2];
            kfts_pkg::OPN_P3:  v = p_ff[3];
            kfts_pkg::OPN_ONE: v = ONE_VAL;
            default:           v = 32'sd0;
         endcase
      end
      return v;
   endfunction

   // operand select reads registers inside the function, so keep it in always_comb
   always_comb begin
      opa = opnd_val(uop.srca, rda_ff);
      opb = opnd_val(uop.srcb, rdb_ff);
   end

   assign trial   = {rem_ff, quo_ff[NW-1]};
   assign rnd     = prod_ff + RND_VAL;
   assign shifted = rnd >>> FRAC_BITS;

   // writeback value of the shared unit
   always_comb begin
      wb_in      = 1'b0;
      wb_data_in = 32'sd0;
      case (state_ff)
         ST_EXEC: begin
            case (uop.op)
               kfts_pkg::OP_ADD: begin
                  wb_in      = 1'b1;
                  wb_data_in = kfts_pkg::sat32({{33{opa[31]}}, opa} + {{33{opb[31]}}, opb});
               end
               kfts_pkg::OP_SUB: begin
                  wb_in      = 1'b1;
                  wb_data_in = kfts_pkg::sat32({{33{opa[31]}}, opa} - {{33{opb[31]}}, opb});
               end
               kfts_pkg::OP_DIV: begin
                  // zero divisor: gain forced to zero
                  wb_in      = (opb == 32'sd0);
                  wb_data_in = 32'sd0;
               end
               default: begin
                  wb_in = 1'b0;
               end
            endcase
         end
         ST_MULFIN: begin
            wb_in      = 1'b1;
            wb_data_in = kfts_pkg::sat32({shifted[63], shifted});
         end
         ST_DIVFIN: begin
            wb_in = 1'b1;
            if (!div_neg_ff) begin
               wb_data_in = (quo_ff > NW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : quo_ff[31:0];
            end else begin
               wb_data_in = (quo_ff > NW'(32'h8000_0000)) ? 32'sh8000_0000
                                                          : 32'(-quo_ff[31:0]);
            end
         end
         default: begin
            wb_in = 1'b0;
         end
      endcase
   end

   // scratch memory: two registered reads, one write
   always_ff @(posedge clock) begin
      if (state_ff == ST_FETCH) begin
         rda_ff <= scratch_mem[uop.srca[4:0]];
         rdb_ff <= scratch_mem[uop.srcb[4:0]];
      end
      if (wb_in && (uop.dst < 6'd32)) begin
         scratch_mem[uop.dst[4:0]] <= wb_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pc_ff         <= '0;
         trans0_ff     <= 64'h0000_0001_0000_0000;
         trans1_ff     <= 64'h0000_0000_0001_0000;
         noise0_ff     <= 64'd0;
         noise1_ff     <= 64'd0;
         meas_ff       <= 64'h0000_0001_0000_0000;
         mnoise_ff     <= 31'h0001_0000;
         x_ff[0]       <= 32'sd0;
         x_ff[1]       <= 32'sd0;
         p_ff[0]       <= 32'sd0;
         p_ff[1]       <= 32'sd0;
         p_ff[2]       <= 32'sd0;
         p_ff[3]       <= 32'sd0;
         fault_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            case (csr_paddr[5:3])
               kfts_pkg::REG_TRANS0: trans0_ff <= csr_pwdata;
               kfts_pkg::REG_TRANS1: trans1_ff <= csr_pwdata;
               kfts_pkg::REG_NOISE0: noise0_ff <= csr_pwdata;
               kfts_pkg::REG_NOISE1: noise1_ff <= csr_pwdata;
               kfts_pkg::REG_MEAS:   meas_ff   <= csr_pwdata;
               kfts_pkg::REG_MNOISE: mnoise_ff <= csr_pwdata[30:0];
               default: ;
            endcase
         end

         // the finish state reloads the output register itself
         if (rsp_tvalid_ff && rsp_tready && (state_ff != ST_FINISH)) begin
            rsp_tvalid_ff <= 1'b0;
         end

         if (wb_in) begin
            case (uop.dst)
               kfts_pkg::OPN_X0: x_ff[0] <= wb_data_in;
               kfts_pkg::OPN_X1: x_ff[1] <= wb_data_in;
               kfts_pkg::OPN_P0: p_ff[0] <= wb_data_in;
               kfts_pkg::OPN_P1: p_ff[1] <= wb_data_in;
               kfts_pkg::OPN_P2: p_ff[2] <= wb_data_in;
               kfts_pkg::OPN_P3: p_ff[3] <= wb_data_in;
               default: ;
            endcase
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  z_ff     <= req_tdata;
                  fault_ff <= 1'b0;
                  pc_ff    <= '0;
                  state_ff <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               case (uop.op)
                  kfts_pkg::OP_MUL: begin
                     prod_ff  <= opa * opb;
                     state_ff <= ST_MULFIN;
                  end
                  kfts_pkg::OP_DIV: begin
                     if (opb == 32'sd0) begin
                        fault_ff <= 1'b1;
                        pc_ff    <= pc_ff + 7'd1;
                        state_ff <= ST_FETCH;
                     end else begin
                        div_neg_ff <= opa[31] ^ opb[31];
                        quo_ff     <= {(opa[31] ? 32'(-opa) : 32'(opa)), {FRAC_BITS{1'b0}}};
                        den_ff     <= opb[31] ? 32'(-opb) : 32'(opb);
                        rem_ff     <= 32'd0;
                        cnt_ff     <= '0;
                        state_ff   <= ST_DIVRUN;
                     end
                  end
                  default: begin
                     if (pc_ff == kfts_pkg::LAST_PC) begin
                        state_ff <= ST_FINISH;
                     end else begin
                        pc_ff    <= pc_ff + 7'd1;
                        state_ff <= ST_FETCH;
                     end
                  end
               endcase
            end
            ST_MULFIN: begin
               if (pc_ff == kfts_pkg::LAST_PC) begin
                  state_ff <= ST_FINISH;
               end else begin
                  pc_ff    <= pc_ff + 7'd1;
                  state_ff <= ST_FETCH;
               end
            end
            ST_DIVRUN: begin
               // one quotient bit per cycle
               if (trial >= {1'b0, den_ff}) begin
                  rem_ff <= 32'(trial - {1'b0, den_ff});
                  quo_ff <= {quo_ff[NW-2:0], 1'b1};
               end else begin
                  rem_ff <= trial[31:0];
                  quo_ff <= {quo_ff[NW-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff == CW'(NW - 1)) begin
                  state_ff <= ST_DIVFIN;
               end
            end
            ST_DIVFIN: begin
               pc_ff    <= pc_ff + 7'd1;
               state_ff <= ST_FETCH;
            end
            ST_FINISH: begin
               // hold until the output register is free
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= {x_ff[1], x_ff[0]};
                  rsp_tuser_ff  <= fault_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== hw/rtl/kfts_checker.sv =====
// Port-level checker for kalman_filter_two_state, bound to the top level.
// Uses the assertion macros from kalman_filter_two_state_macros.svh.
`include "kalman_filter_two_state_macros.svh"

module kfts_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser
);

   // an accepted beat keeps the sequencer busy for the next cycle
   `KFTS_ASSERT_NEXT(busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)

   // a stalled result holds
   `KFTS_ASSERT_NEXT(rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // reset leaves an empty output and an idle input side
   `KFTS_ASSERT_NEXT_ALWAYS(reset_clears, clock, reset, !rsp_tvalid && req_tready)

endmodule

bind kalman_filter_two_state kfts_checker u_kfts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
